### rtl/brfaw_pkg.sv
// Shared types and constants for the byte ring FIFO with all-or-nothing write bursts.
// No dependencies; compile first.
package brfaw_pkg;

    localparam int DEPTH_DEFAULT   = 1024;
    localparam int MAX_RUN_DEFAULT = 64;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 7;
    localparam int KIND_W   = 2;
    localparam int STORED_W = 10;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_WRITE_DONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ_BYTE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ_EMPTY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [DATA_W-1:0]   read_byte;
        logic [LEN_W-1:0]    count;
        logic [STORED_W-1:0] stored;
        logic                last;
    } result_t;

endpackage

### rtl/brfaw_item_if.sv
// Input channel: valid/ready handshake with the request fields.
// Depends on brfaw_pkg.
interface brfaw_item_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [brfaw_pkg::DATA_W-1:0]  data_byte;
    logic [brfaw_pkg::LEN_W-1:0]   length;
    logic                          first_of_burst;

    modport source (output valid, output operation, output data_byte, output length,
                    output first_of_burst, input ready);
    modport sink   (input valid, input operation, input data_byte, input length,
                    input first_of_burst, output ready);
endinterface

### rtl/brfaw_result_if.sv
// Output channel: valid/ready handshake with the result fields.
// Depends on brfaw_pkg.
interface brfaw_result_if;
    logic                            valid;
    logic                            ready;
    logic [brfaw_pkg::KIND_W-1:0]    kind;
    logic [brfaw_pkg::DATA_W-1:0]    read_byte;
    logic [brfaw_pkg::LEN_W-1:0]     count;
    logic [brfaw_pkg::STORED_W-1:0]  stored;
    logic                            last;

    modport source (output valid, output kind, output read_byte, output count,
                    output stored, output last, input ready);
    modport sink   (input valid, input kind, input read_byte, input count,
                    input stored, input last, output ready);
endinterface

### rtl/byte_ring_fifo_atomic_write_core.sv
// Byte ring FIFO with all-or-nothing write bursts, built around one ring memory.
// Depends on brfaw_pkg, brfaw_item_if, brfaw_result_if.
//
// A write byte is checked against the free space on the first byte of its burst,
// written into the ring memory at once unless the burst is dropped, and made
// readable by a write pointer update on the last byte, which also returns one
// write-done result. For a read request that finds n bytes (n up to MAX_RUN),
// the sequencer issues one ring memory read per cycle on the single read port
// while the result queue has room, and the data comes back in the next cycle
// into a two-entry result queue; no new item is taken until the last read has come back.
// Empty reads push their result directly. Results wait in the queue, so a stalled output
// holds at most two results before the input stalls. The ring memory needs no
// clearing after reset: only committed bytes are ever read.
module byte_ring_fifo_atomic_write_core #(
    parameter int DEPTH   = brfaw_pkg::DEPTH_DEFAULT,
    parameter int MAX_RUN = brfaw_pkg::MAX_RUN_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    brfaw_item_if.sink       item,
    brfaw_result_if.source   result
);

    localparam int PW = $clog2(DEPTH);
    localparam int SW = ((PW + 1 > brfaw_pkg::LEN_W + 1) ? PW + 1 : brfaw_pkg::LEN_W + 1) + 1;
    localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);
    localparam logic [brfaw_pkg::LEN_W-1:0] MAX_RUN_L = brfaw_pkg::LEN_W'(MAX_RUN);
    localparam logic [PW-1:0] LAST_ADDR = PW'(DEPTH - 1);

    // ring memory
    logic [brfaw_pkg::DATA_W-1:0] ring_mem [DEPTH];
    logic                         mem_we;
    logic [PW-1:0]                mem_waddr;
    logic                         mem_re;
    logic [brfaw_pkg::DATA_W-1:0] rd_data_reg;

    // pointers and burst state
    logic [PW-1:0]                wp_reg, wp_next;
    logic [PW-1:0]                rp_reg, rp_next;
    logic [brfaw_pkg::LEN_W-1:0]  burst_left_reg, burst_left_next;
    logic [brfaw_pkg::LEN_W-1:0]  burst_total_reg, burst_total_next;
    logic                         burst_drop_reg, burst_drop_next;

    // read run sequencer
    logic                          run_active_reg, run_active_next;
    logic [PW-1:0]                 rd_addr_reg, rd_addr_next;
    logic [brfaw_pkg::LEN_W-1:0]   run_left_reg, run_left_next;
    logic [brfaw_pkg::LEN_W-1:0]   run_len_reg, run_len_next;
    logic [brfaw_pkg::STORED_W-1:0] run_stored_reg, run_stored_next;
    logic                          inflight_reg, inflight_next;
    logic                          inflight_last_reg, inflight_last_next;

    // result queue
    brfaw_pkg::result_t q_reg [2];
    logic               q_head_reg, q_head_next;
    logic [1:0]         q_cnt_reg, q_cnt_next;
    logic               push;
    brfaw_pkg::result_t push_data;
    logic               pop;
    logic               q_tail;
    logic               issue;
    logic [1:0]         q_occ;

    logic               accept;
    logic [SW-1:0]      fill;
    logic [SW-1:0]      free_space;
    logic [brfaw_pkg::LEN_W-1:0] tot;
    logic [brfaw_pkg::LEN_W-1:0] left;
    logic [brfaw_pkg::LEN_W-1:0] off;
    logic [brfaw_pkg::LEN_W-1:0] written;
    logic [brfaw_pkg::LEN_W-1:0] want;
    logic [brfaw_pkg::LEN_W-1:0] run;
    logic               drop;
    logic [SW-1:0]      addr_sum;
    logic [SW-1:0]      wp_sum;
    logic [SW-1:0]      rp_sum;

    assign item.ready = !run_active_reg && !inflight_reg && (q_cnt_reg != 2'd2);
    assign accept     = item.valid && item.ready;

    assign result.valid     = (q_cnt_reg != 2'd0);
    assign result.kind      = q_reg[q_head_reg].kind;
    assign result.read_byte = q_reg[q_head_reg].read_byte;
    assign result.count     = q_reg[q_head_reg].count;
    assign result.stored    = q_reg[q_head_reg].stored;
    assign result.last      = q_reg[q_head_reg].last;
    assign pop              = result.valid && result.ready;

    // issue a read only if its data is sure to find a queue slot
    assign q_occ  = q_cnt_reg + {1'b0, inflight_reg};
    assign issue  = run_active_reg && (q_occ <= ({1'b0, pop} + 2'd1));
    assign mem_re = issue;

    assign fill = (wp_reg >= rp_reg) ? SW'(wp_reg) - SW'(rp_reg)
                                     : SW'(wp_reg) + DEPTH_W - SW'(rp_reg);
    assign free_space = DEPTH_W - SW'(1) - fill;

    always_comb
    begin
        wp_next            = wp_reg;
        rp_next            = rp_reg;
        burst_left_next    = burst_left_reg;
        burst_total_next   = burst_total_reg;
        burst_drop_next    = burst_drop_reg;
        run_active_next    = run_active_reg;
        rd_addr_next       = rd_addr_reg;
        run_left_next      = run_left_reg;
        run_len_next       = run_len_reg;
        run_stored_next    = run_stored_reg;
        inflight_next      = issue;
        inflight_last_next = issue && (run_left_reg == brfaw_pkg::LEN_W'(1));
        mem_we             = 1'b0;
        push               = 1'b0;
        push_data          = '0;

        tot      = burst_total_reg;
        left     = burst_left_reg;
        drop     = burst_drop_reg;
        off      = '0;
        written  = '0;
        addr_sum = '0;
        wp_sum   = '0;
        rp_sum   = '0;

        want = (item.length > MAX_RUN_L) ? MAX_RUN_L : item.length;
        run  = (fill < SW'(want)) ? brfaw_pkg::LEN_W'(fill) : want;

        // read data coming back from the memory
        if (inflight_reg)
        begin
            push                = 1'b1;
            push_data.kind      = brfaw_pkg::KIND_READ_BYTE;
            push_data.read_byte = rd_data_reg;
            push_data.count     = run_len_reg;
            push_data.stored    = run_stored_reg;
            push_data.last      = inflight_last_reg;
        end

        if (issue)
        begin
            rd_addr_next  = (rd_addr_reg == LAST_ADDR) ? '0 : rd_addr_reg + PW'(1);
            run_left_next = run_left_reg - brfaw_pkg::LEN_W'(1);
            if (run_left_reg == brfaw_pkg::LEN_W'(1))
            begin
                run_active_next = 1'b0;
            end
        end

        if (accept && item.operation == brfaw_pkg::OP_WRITE)
        begin
            if (item.first_of_burst)
            begin
                tot  = item.length;
                left = item.length;
                drop = SW'(item.length) > free_space;
            end
            burst_total_next = tot;
            burst_drop_next  = drop;
            burst_left_next  = left;
            if (item.first_of_burst && item.length == '0)
            begin
                // empty burst answers at once
                push             = 1'b1;
                push_data.kind   = brfaw_pkg::KIND_WRITE_DONE;
                push_data.count  = '0;
                push_data.stored = brfaw_pkg::STORED_W'(fill);
                push_data.last   = 1'b1;
            end
            else if (left != '0)
            begin
                off      = tot - left;
                addr_sum = SW'(wp_reg) + SW'(off);
                if (addr_sum >= DEPTH_W)
                begin
                    addr_sum = addr_sum - DEPTH_W;
                end
                mem_we          = !drop;
                burst_left_next = left - brfaw_pkg::LEN_W'(1);
                if (left == brfaw_pkg::LEN_W'(1))
                begin
                    written = drop ? '0 : tot;
                    wp_sum  = SW'(wp_reg) + SW'(written);
                    if (wp_sum >= DEPTH_W)
                    begin
                        wp_sum = wp_sum - DEPTH_W;
                    end
                    wp_next          = PW'(wp_sum);
                    burst_drop_next  = 1'b0;
                    push             = 1'b1;
                    push_data.kind   = brfaw_pkg::KIND_WRITE_DONE;
                    push_data.count  = written;
                    push_data.stored = brfaw_pkg::STORED_W'(fill + SW'(written));
                    push_data.last   = 1'b1;
                end
            end
        end

        if (accept && item.operation == brfaw_pkg::OP_READ)
        begin
            if (run == '0)
            begin
                push             = 1'b1;
                push_data.kind   = brfaw_pkg::KIND_READ_EMPTY;
                push_data.count  = '0;
                push_data.stored = brfaw_pkg::STORED_W'(fill);
                push_data.last   = 1'b1;
            end
            else
            begin
                // commit the read pointer now; the sequencer walks the bytes
                rp_sum = SW'(rp_reg) + SW'(run);
                if (rp_sum >= DEPTH_W)
                begin
                    rp_sum = rp_sum - DEPTH_W;
                end
                rp_next         = PW'(rp_sum);
                run_active_next = 1'b1;
                rd_addr_next    = rp_reg;
                run_left_next   = run;
                run_len_next    = run;
                run_stored_next = brfaw_pkg::STORED_W'(fill - SW'(run));
            end
        end
    end

    assign mem_waddr = PW'(addr_sum);

    // queue pointers
    assign q_tail = q_head_reg ^ q_cnt_reg[0];

    always_comb
    begin
        q_head_next = q_head_reg;
        q_cnt_next  = q_cnt_reg;
        if (pop)
        begin
            q_head_next = ~q_head_reg;
        end
        case ({push, pop})
            2'b10:   q_cnt_next = q_cnt_reg + 2'd1;
            2'b01:   q_cnt_next = q_cnt_reg - 2'd1;
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= item.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[q_tail] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg            <= '0;
            rp_reg            <= '0;
            burst_left_reg    <= '0;
            burst_total_reg   <= '0;
            burst_drop_reg    <= 1'b0;
            run_active_reg    <= 1'b0;
            rd_addr_reg       <= '0;
            run_left_reg      <= '0;
            run_len_reg       <= '0;
            run_stored_reg    <= '0;
            inflight_reg      <= 1'b0;
            inflight_last_reg <= 1'b0;
            q_head_reg        <= 1'b0;
            q_cnt_reg         <= 2'd0;
        end
        else
        begin
            wp_reg            <= wp_next;
            rp_reg            <= rp_next;
            burst_left_reg    <= burst_left_next;
            burst_total_reg   <= burst_total_next;
            burst_drop_reg    <= burst_drop_next;
            run_active_reg    <= run_active_next;
            rd_addr_reg       <= rd_addr_next;
            run_left_reg      <= run_left_next;
            run_len_reg       <= run_len_next;
            run_stored_reg    <= run_stored_next;
            inflight_reg      <= inflight_next;
            inflight_last_reg <= inflight_last_next;
            q_head_reg        <= q_head_next;
            q_cnt_reg         <= q_cnt_next;
        end
    end

endmodule

### rtl/brfaw_checker.sv
// Port-level checks for byte_ring_fifo_atomic_write_core, with the bind that attaches them.
// Depends on brfaw_pkg.
module brfaw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [brfaw_pkg::KIND_W-1:0]    result_kind,
    input logic [brfaw_pkg::LEN_W-1:0]     result_count,
    input logic [brfaw_pkg::STORED_W-1:0]  result_stored,
    input logic                            result_last
);

    logic transfer;
    assign transfer = result_valid && result_ready;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_kind)
            && $stable(result_count) && $stable(result_stored))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == brfaw_pkg::KIND_READ_EMPTY
            |-> result_last && result_count == '0)
        else $error("empty read result is not a single zero-count result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == brfaw_pkg::KIND_WRITE_DONE |-> result_last)
        else $error("write done result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == brfaw_pkg::KIND_READ_BYTE |-> result_count != '0)
        else $error("read byte with zero run count");

    // the bytes of one run share count and stored level
    assert property (@(posedge clk) disable iff (!rst_n)
        transfer && result_kind == brfaw_pkg::KIND_READ_BYTE && !result_last
            |=> !result_valid || (result_kind == brfaw_pkg::KIND_READ_BYTE
                && result_count == $past(result_count)
                && result_stored == $past(result_stored)))
        else $error("read run broken");

endmodule

bind byte_ring_fifo_atomic_write_core brfaw_checker u_brfaw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_kind   (result.kind),
    .result_count  (result.count),
    .result_stored (result.stored),
    .result_last   (result.last)
);

### tb/sv/byte_ring_fifo_atomic_write_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_fifo_atomic_write_core: directed and random
// write bursts and read requests, checked against an in-bench copy of the ring.
// Depends on brfaw_pkg, brfaw_item_if, brfaw_result_if and the core.
module byte_ring_fifo_atomic_write_core_tb;

    localparam int RING_DEPTH    = brfaw_pkg::DEPTH_DEFAULT;
    localparam int RUN_MAX       = brfaw_pkg::MAX_RUN_DEFAULT;
    localparam int IDLE_PCT      = 37;
    localparam int RANDOM_ITEMS  = 260;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = RUN_MAX + 16;
    localparam int REPORT_MAX    = 10;

    logic clk;
    logic rst_n;
    logic steady;

    brfaw_item_if   item_ch ();
    brfaw_result_if result_ch ();

    byte_ring_fifo_atomic_write_core #(
        .DEPTH   (RING_DEPTH),
        .MAX_RUN (RUN_MAX)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Shadow copy of the ring and its pointers
    logic [brfaw_pkg::DATA_W-1:0]   ring_copy [0:RING_DEPTH-1];
    logic [brfaw_pkg::STORED_W-1:0] head_ptr;
    logic [brfaw_pkg::STORED_W-1:0] tail_ptr;
    logic [brfaw_pkg::LEN_W-1:0]    burst_left;
    logic [brfaw_pkg::LEN_W-1:0]    burst_len;
    logic                           burst_drop;
    brfaw_pkg::result_t             awaited_results [$];

    int mismatches     = 0;
    int cycles         = 0;
    int bursts_closed  = 0;
    int bursts_empty   = 0;
    int bytes_read     = 0;
    int empty_reads    = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [brfaw_pkg::STORED_W-1:0] ring_level();
        return tail_ptr - head_ptr;
    endfunction

    function automatic void queue_result(logic [brfaw_pkg::KIND_W-1:0] kind,
                                         logic [brfaw_pkg::DATA_W-1:0] data,
                                         logic [brfaw_pkg::LEN_W-1:0] count, logic last);
        brfaw_pkg::result_t r;
        r.kind      = kind;
        r.read_byte = data;
        r.count     = count;
        r.stored    = ring_level();
        r.last      = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void predict_transfer(logic op, logic [brfaw_pkg::DATA_W-1:0] data,
                                             logic [brfaw_pkg::LEN_W-1:0] len,
                                             logic is_first);
        int                             free_bytes;
        int                             run_len;
        bit                             answered;
        logic [brfaw_pkg::STORED_W-1:0] start;
        answered = 1'b0;
        if (op == brfaw_pkg::OP_WRITE)
        begin
            if (is_first)
            begin
                free_bytes = RING_DEPTH - 1 - int'(ring_level());
                burst_len  = len;
                burst_left = len;
                burst_drop = int'(len) > free_bytes;
                if (len == '0)
                begin
                    queue_result(brfaw_pkg::KIND_WRITE_DONE, '0, '0, 1'b1);
                    answered = 1'b1;
                end
            end
            // stray bytes fall through with nothing left in the burst
            if (!answered && burst_left != '0)
            begin
                if (!burst_drop)
                    ring_copy[tail_ptr + brfaw_pkg::STORED_W'(burst_len - burst_left)] = data;
                burst_left = burst_left - brfaw_pkg::LEN_W'(1);
                if (burst_left == '0)
                begin
                    // commit the whole burst at once
                    if (!burst_drop)
                        tail_ptr = tail_ptr + brfaw_pkg::STORED_W'(burst_len);
                    queue_result(brfaw_pkg::KIND_WRITE_DONE, '0,
                                 burst_drop ? '0 : burst_len, 1'b1);
                    burst_drop = 1'b0;
                end
            end
        end
        else
        begin
            run_len = (int'(len) > RUN_MAX) ? RUN_MAX : int'(len);
            if (int'(ring_level()) < run_len)
                run_len = int'(ring_level());
            if (run_len == 0)
                queue_result(brfaw_pkg::KIND_READ_EMPTY, '0, '0, 1'b1);
            else
            begin
                start    = head_ptr;
                head_ptr = head_ptr + brfaw_pkg::STORED_W'(run_len);
                for (int i = 0; i < run_len; i++)
                    queue_result(brfaw_pkg::KIND_READ_BYTE,
                                 ring_copy[start + brfaw_pkg::STORED_W'(i)],
                                 brfaw_pkg::LEN_W'(run_len), i == run_len - 1);
            end
        end
    endfunction

    function automatic void report_mismatch(string what, brfaw_pkg::result_t want,
                                            brfaw_pkg::result_t seen);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected kind=%0d byte=%02h count=%0d stored=%0d last=%0d",
                     $time, what, want.kind, want.read_byte, want.count, want.stored, want.last,
                     "\n           got      kind=%0d byte=%02h count=%0d stored=%0d last=%0d",
                     seen.kind, seen.read_byte, seen.count, seen.stored, seen.last);
    endfunction

    // Predict on each input transfer first, then check any result transfer
    always @(posedge clk)
    begin
        brfaw_pkg::result_t seen;
        brfaw_pkg::result_t want;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                predict_transfer(item_ch.operation, item_ch.data_byte, item_ch.length,
                                 item_ch.first_of_burst);
            if (result_ch.valid && result_ch.ready)
            begin
                seen.kind      = result_ch.kind;
                seen.read_byte = result_ch.read_byte;
                seen.count     = result_ch.count;
                seen.stored    = result_ch.stored;
                seen.last      = result_ch.last;
                if (awaited_results.size() == 0)
                    report_mismatch("result with nothing awaited", '0, seen);
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.kind !== want.kind || seen.read_byte !== want.read_byte ||
                        seen.count !== want.count || seen.stored !== want.stored ||
                        seen.last !== want.last)
                        report_mismatch("result mismatch", want, seen);
                    if (want.kind == brfaw_pkg::KIND_WRITE_DONE)
                    begin
                        bursts_closed++;
                        if (want.count == '0)
                            bursts_empty++;
                    end
                    else if (want.kind == brfaw_pkg::KIND_READ_BYTE)
                        bytes_read++;
                    else
                        empty_reads++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycles, awaited_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk)
        result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    task automatic send_item(logic op, logic [brfaw_pkg::DATA_W-1:0] data,
                             logic [brfaw_pkg::LEN_W-1:0] len, logic is_first);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.operation      <= op;
        item_ch.data_byte      <= data;
        item_ch.length         <= len;
        item_ch.first_of_burst <= is_first;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Send the first n bytes of a burst of len; n below len leaves it open
    task automatic send_burst(int len, int n, bit mix_reads);
        send_item(brfaw_pkg::OP_WRITE, brfaw_pkg::DATA_W'($urandom),
                  brfaw_pkg::LEN_W'(len), 1'b1);
        for (int i = 1; i < n; i++)
        begin
            if (mix_reads && $urandom_range(0, 9) == 0)
                send_item(brfaw_pkg::OP_READ, brfaw_pkg::DATA_W'($urandom),
                          brfaw_pkg::LEN_W'($urandom_range(0, 20)), 1'($urandom));
            send_item(brfaw_pkg::OP_WRITE, brfaw_pkg::DATA_W'($urandom),
                      brfaw_pkg::LEN_W'($urandom), 1'b0);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_reads();
        send_item(brfaw_pkg::OP_READ, 8'hFF, 7'd5, 1'b1);
        send_item(brfaw_pkg::OP_READ, 8'h00, 7'd0, 1'b0);
        send_item(brfaw_pkg::OP_WRITE, 8'h3C, 7'd9, 1'b0);     // stray byte, no result
        send_item(brfaw_pkg::OP_WRITE, 8'h00, 7'd0, 1'b1);     // empty burst
    endtask

    task automatic test_burst_shapes();
        send_item(brfaw_pkg::OP_WRITE, 8'h00, 7'd3, 1'b1);
        send_item(brfaw_pkg::OP_WRITE, 8'hFF, brfaw_pkg::LEN_W'($urandom), 1'b0);
        send_item(brfaw_pkg::OP_WRITE, 8'hA5, brfaw_pkg::LEN_W'($urandom), 1'b0);
        send_item(brfaw_pkg::OP_READ, 8'h00, 7'd0, 1'b0);
        // abandon an open burst by starting another
        send_item(brfaw_pkg::OP_WRITE, 8'h11, 7'd4, 1'b1);
        send_item(brfaw_pkg::OP_WRITE, 8'h22, 7'd4, 1'b0);
        send_item(brfaw_pkg::OP_WRITE, 8'h33, 7'd2, 1'b1);
        send_item(brfaw_pkg::OP_WRITE, 8'h44, 7'd0, 1'b0);
        send_item(brfaw_pkg::OP_WRITE, 8'h80, 7'd1, 1'b1);
        send_item(brfaw_pkg::OP_READ, 8'h00, 7'd127, 1'b0);
    endtask

    task automatic test_reads_during_burst();
        send_item(brfaw_pkg::OP_WRITE, 8'h7F, 7'd2, 1'b1);
        send_item(brfaw_pkg::OP_WRITE, 8'hFE, 7'd0, 1'b0);
        send_item(brfaw_pkg::OP_WRITE, 8'h01, 7'd3, 1'b1);
        send_item(brfaw_pkg::OP_READ, 8'hFF, 7'd64, 1'b1);     // sees only the committed pair
        send_item(brfaw_pkg::OP_WRITE, 8'h02, 7'd0, 1'b0);
        send_item(brfaw_pkg::OP_WRITE, 8'h03, 7'd127, 1'b0);
        send_item(brfaw_pkg::OP_READ, 8'h00, 7'd65, 1'b0);     // cut to the three committed bytes
    endtask

    task automatic test_steady_stretch();
        steady = 1'b1;
        send_burst(100, 100, 1'b0);
        send_burst(24, 24, 1'b0);
        // a full-length run and a run of the 60 bytes left drain the ring, the third finds it empty
        for (int i = 0; i < 3; i++)
            send_item(brfaw_pkg::OP_READ, brfaw_pkg::DATA_W'($urandom),
                      brfaw_pkg::LEN_W'($urandom_range(64, 127)), 1'($urandom));
        steady = 1'b0;
        hold_until_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        int pick;
        int len;
        int n;
        int next_drain;
        sent       = 0;
        next_drain = 150;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 127)
                                                  : $urandom_range(1, 16);
                n   = ($urandom_range(0, 14) == 0) ? $urandom_range(1, len) : len;
                send_burst(len, n, 1'b1);
                sent += n;
            end
            else if (pick < 82)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 24);
                send_item(brfaw_pkg::OP_READ, brfaw_pkg::DATA_W'($urandom),
                          brfaw_pkg::LEN_W'(len), 1'($urandom));
                sent++;
            end
            else if (pick < 90)
            begin
                send_item(brfaw_pkg::OP_WRITE, brfaw_pkg::DATA_W'($urandom), 7'd0, 1'b1);
                sent++;
            end
            else
                send_item(brfaw_pkg::OP_WRITE, brfaw_pkg::DATA_W'($urandom),
                          brfaw_pkg::LEN_W'($urandom), 1'b0);
            if (sent >= next_drain)
            begin
                hold_until_drained();
                next_drain += 150;
            end
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.operation      = brfaw_pkg::OP_WRITE;
        item_ch.data_byte      = '0;
        item_ch.length         = '0;
        item_ch.first_of_burst = 1'b0;
        result_ch.ready        = 1'b0;
        head_ptr               = '0;
        tail_ptr               = '0;
        burst_left             = '0;
        burst_len              = '0;
        burst_drop             = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_reads();
        test_burst_shapes();
        test_reads_during_burst();
        hold_until_drained();
        test_steady_stretch();
        test_random_traffic();

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d closed bursts (%0d writing nothing), %0d bytes read back,",
                 bursts_closed, bursts_empty, bytes_read);
        $display("%0d empty reads and a stretch with no idling in %0d cycles",
                 empty_reads, cycles);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
